>>> src/nts_pkg.sv
// Package for the nearest-three selector: parameter defaults, fixed field widths,
// register indexes and the control struct between the distance and select stages.
// No dependencies.
`timescale 1ns / 1ps

package nts_pkg;

  localparam int unsigned KEEP_COUNT_DEF = 3;
  localparam int unsigned ID_BITS_DEF    = 16;
  localparam int unsigned COORD_BITS_DEF = 16;

  // result fields are fixed width
  localparam int unsigned OUT_ID_BITS = 16;
  localparam int unsigned SLOT_OUTS   = 3;
  localparam int unsigned COUNT_BITS  = 2;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_REF_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_Y = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_Z = CFG_IDX_BITS'(2);

  typedef struct packed {
    logic valid;
    logic last;
  } dist_ctrl_t;

endpackage

>>> src/nts_cand_if.sv
// Candidate input channel: valid/ready plus id, coordinates and last flag.
// Depends on nts_pkg for default widths.
`timescale 1ns / 1ps

interface nts_cand_if #(
  parameter int unsigned ID_BITS    = nts_pkg::ID_BITS_DEF,
  parameter int unsigned COORD_BITS = nts_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic        [ID_BITS-1:0]    cand_id;
  logic signed [COORD_BITS-1:0] cand_x;
  logic signed [COORD_BITS-1:0] cand_y;
  logic signed [COORD_BITS-1:0] cand_z;
  logic                         is_last;

  modport source (output valid, cand_id, cand_x, cand_y, cand_z, is_last, input ready);
  modport sink   (input valid, cand_id, cand_x, cand_y, cand_z, is_last, output ready);
endinterface

>>> src/nts_res_if.sv
// Result output channel: valid/ready plus the three slot ids and the held count.
// Depends on nts_pkg for field widths.
`timescale 1ns / 1ps

interface nts_res_if;
  import nts_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OUT_ID_BITS-1:0]  slot0_id;
  logic [OUT_ID_BITS-1:0]  slot1_id;
  logic [OUT_ID_BITS-1:0]  slot2_id;
  logic [COUNT_BITS-1:0]   held_count;

  modport source (output valid, slot0_id, slot1_id, slot2_id, held_count, input ready);
  modport sink   (input valid, slot0_id, slot1_id, slot2_id, held_count, output ready);
endinterface

>>> src/nts_cfg_if.sv
// Configuration write channel: valid/ready plus register index and write data.
// Depends on nts_pkg for field widths.
`timescale 1ns / 1ps

interface nts_cfg_if;
  import nts_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/nts_dist.sv
// Input register and squared-distance stage of the nearest-three selector.
// Depends on nts_pkg and nts_cand_if.
`timescale 1ns / 1ps

module nts_dist #(
  parameter int unsigned ID_BITS    = nts_pkg::ID_BITS_DEF,
  parameter int unsigned COORD_BITS = nts_pkg::COORD_BITS_DEF,
  parameter int unsigned DIST_W     = 2 * COORD_BITS + 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  nts_cand_if.sink               cand_i,
  input  logic [COORD_BITS-1:0]  ref_x_i,
  input  logic [COORD_BITS-1:0]  ref_y_i,
  input  logic [COORD_BITS-1:0]  ref_z_i,
  output nts_pkg::dist_ctrl_t    ctrl_o,
  input  logic                   ready_i,
  output logic [ID_BITS-1:0]     id_o,
  output logic [DIST_W-1:0]      dist_o
);
  import nts_pkg::*;

  logic                  in_valid_q;
  logic [ID_BITS-1:0]    in_id_q;
  logic [COORD_BITS-1:0] in_x_q, in_y_q, in_z_q;
  logic                  in_last_q;

  dist_ctrl_t            ctrl_q;
  logic [ID_BITS-1:0]    id_q;
  logic [DIST_W-1:0]     dist_q;

  logic                  load_ok;
  logic                  in_ready;

  logic [COORD_BITS:0]   dx, dy, dz;
  logic [COORD_BITS:0]   ax, ay, az;
  logic [DIST_W-1:0]     sqx, sqy, sqz;
  logic [DIST_W-1:0]     dist_d;

  assign load_ok      = !ctrl_q.valid || ready_i;
  assign in_ready     = !in_valid_q || load_ok;
  assign cand_i.ready = in_ready;

  // one extra bit keeps the difference exact
  assign dx = {in_x_q[COORD_BITS-1], in_x_q} - {ref_x_i[COORD_BITS-1], ref_x_i};
  assign dy = {in_y_q[COORD_BITS-1], in_y_q} - {ref_y_i[COORD_BITS-1], ref_y_i};
  assign dz = {in_z_q[COORD_BITS-1], in_z_q} - {ref_z_i[COORD_BITS-1], ref_z_i};

  assign ax = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
  assign ay = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
  assign az = dz[COORD_BITS] ? (~dz + 1'b1) : dz;

  assign sqx = DIST_W'(ax) * DIST_W'(ax);
  assign sqy = DIST_W'(ay) * DIST_W'(ay);
  assign sqz = DIST_W'(az) * DIST_W'(az);

  assign dist_d = sqx + sqy + sqz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      ctrl_q     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= cand_i.valid;
      end
      if (load_ok) begin
        ctrl_q.valid <= in_valid_q;
        ctrl_q.last  <= in_last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && cand_i.valid) begin
      in_id_q   <= cand_i.cand_id;
      in_x_q    <= cand_i.cand_x;
      in_y_q    <= cand_i.cand_y;
      in_z_q    <= cand_i.cand_z;
      in_last_q <= cand_i.is_last;
    end
    if (load_ok && in_valid_q) begin
      id_q   <= in_id_q;
      dist_q <= dist_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign id_o   = id_q;
  assign dist_o = dist_q;

endmodule

>>> src/nts_select.sv
// Slot table, farthest-slot tracking and result register of the selector.
// Depends on nts_pkg and nts_res_if.
`timescale 1ns / 1ps

module nts_select #(
  parameter int unsigned KEEP_COUNT = nts_pkg::KEEP_COUNT_DEF,
  parameter int unsigned ID_BITS    = nts_pkg::ID_BITS_DEF,
  parameter int unsigned DIST_W     = 34
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nts_pkg::dist_ctrl_t  ctrl_i,
  output logic                 ready_o,
  input  logic [ID_BITS-1:0]   id_i,
  input  logic [DIST_W-1:0]    dist_i,
  nts_res_if.source            res_o
);
  import nts_pkg::*;

  localparam int unsigned FILL_W = $clog2(KEEP_COUNT + 1);
  localparam int unsigned SLOT_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

  logic [ID_BITS-1:0]     ids_q   [KEEP_COUNT];
  logic [ID_BITS-1:0]     ids_d   [KEEP_COUNT];
  logic [DIST_W-1:0]      dists_q [KEEP_COUNT];
  logic [DIST_W-1:0]      dists_d [KEEP_COUNT];
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [SLOT_W-1:0]      wslot_q, wslot_d;
  logic [DIST_W-1:0]      wdist_q, wdist_d;

  logic [DIST_W-1:0]      scan_max;
  logic [SLOT_W-1:0]      scan_slot;

  logic                   out_free;
  logic                   take;
  logic                   emit;

  logic [OUT_ID_BITS-1:0] out_id_d [SLOT_OUTS];
  logic                   res_valid_q;
  logic [OUT_ID_BITS-1:0] res_id_q [SLOT_OUTS];
  logic [COUNT_BITS-1:0]  res_count_q;

  assign out_free = !res_valid_q || res_o.ready;
  assign ready_o  = !ctrl_i.valid || !ctrl_i.last || out_free;
  assign take     = ctrl_i.valid && ready_o;
  assign emit     = take && ctrl_i.last;

  always_comb begin
    ids_d     = ids_q;
    dists_d   = dists_q;
    fill_d    = fill_q;
    wslot_d   = wslot_q;
    wdist_d   = wdist_q;
    scan_max  = '0;
    scan_slot = '0;
    if (take) begin
      if (fill_q < FILL_W'(KEEP_COUNT)) begin
        ids_d[fill_q[SLOT_W-1:0]]   = id_i;
        dists_d[fill_q[SLOT_W-1:0]] = dist_i;
        // ties move the farthest mark to the later slot
        if (dist_i >= wdist_q) begin
          wdist_d = dist_i;
          wslot_d = fill_q[SLOT_W-1:0];
        end
        fill_d = fill_q + 1'b1;
      end else if (dist_i < wdist_q) begin
        ids_d[wslot_q]   = id_i;
        dists_d[wslot_q] = dist_i;
        // rescan, ties go to the highest slot
        for (int i = 0; i < KEEP_COUNT; i++) begin
          if (dists_d[i] >= scan_max) begin
            scan_max  = dists_d[i];
            scan_slot = SLOT_W'(i);
          end
        end
        wdist_d = scan_max;
        wslot_d = scan_slot;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < SLOT_OUTS; j++) begin
      if ((j < KEEP_COUNT) && (FILL_W'(j) < fill_d)) begin
        out_id_d[j] = OUT_ID_BITS'(ids_d[(j < KEEP_COUNT) ? j : 0]);
      end else begin
        out_id_d[j] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEEP_COUNT; i++) begin
        ids_q[i]   <= '0;
        dists_q[i] <= '0;
      end
      fill_q      <= '0;
      wslot_q     <= '0;
      wdist_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        for (int i = 0; i < KEEP_COUNT; i++) begin
          ids_q[i]   <= '0;
          dists_q[i] <= '0;
        end
        fill_q  <= '0;
        wslot_q <= '0;
        wdist_q <= '0;
      end else begin
        ids_q   <= ids_d;
        dists_q <= dists_d;
        fill_q  <= fill_d;
        wslot_q <= wslot_d;
        wdist_q <= wdist_d;
      end
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_id_q    <= out_id_d;
      res_count_q <= COUNT_BITS'(fill_d);
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.slot0_id   = res_id_q[0];
  assign res_o.slot1_id   = res_id_q[1];
  assign res_o.slot2_id   = res_id_q[2];
  assign res_o.held_count = res_count_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(KEEP_COUNT))
    else $error("fill count above slot count");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (fill_q == '0) && (wdist_q == '0))
    else $error("state not cleared after result");

  a_worst_tracks_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != '0) |-> (wdist_q == dists_q[wslot_q]))
    else $error("farthest distance does not match its slot");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready) |-> !emit)
    else $error("result overwritten before transfer");

endmodule

>>> src/nearest_three_selector.sv
// A candidate transfer reaches the input register, then the distance register; the
// result of a list goes to the result register when the select stage takes its last item.
// Throughput: one candidate per cycle unless a held result stalls the item flagged last.
// Reset (async, active low) clears the reference point, all slots and the result valid.
// The selector clears its slots after each result.
`timescale 1ns / 1ps

module nearest_three_selector #(
  parameter int unsigned KEEP_COUNT = nts_pkg::KEEP_COUNT_DEF,
  parameter int unsigned ID_BITS    = nts_pkg::ID_BITS_DEF,
  parameter int unsigned COORD_BITS = nts_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nts_cand_if.sink    cand_i,
  nts_res_if.source   res_o,
  nts_cfg_if.sink     cfg_i
);
  import nts_pkg::*;

  localparam int unsigned DIST_W = 2 * COORD_BITS + 2;

  logic [COORD_BITS-1:0] ref_x_q, ref_y_q, ref_z_q;
  dist_ctrl_t            dist_ctrl;
  logic                  sel_ready;
  logic [ID_BITS-1:0]    dist_id;
  logic [DIST_W-1:0]     dist_val;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q <= '0;
      ref_y_q <= '0;
      ref_z_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_REF_X: ref_x_q <= COORD_BITS'(cfg_i.data);
        REG_REF_Y: ref_y_q <= COORD_BITS'(cfg_i.data);
        REG_REF_Z: ref_z_q <= COORD_BITS'(cfg_i.data);
        default: ;
      endcase
    end
  end

  nts_dist #(
    .ID_BITS    (ID_BITS),
    .COORD_BITS (COORD_BITS),
    .DIST_W     (DIST_W)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cand_i  (cand_i),
    .ref_x_i (ref_x_q),
    .ref_y_i (ref_y_q),
    .ref_z_i (ref_z_q),
    .ctrl_o  (dist_ctrl),
    .ready_i (sel_ready),
    .id_o    (dist_id),
    .dist_o  (dist_val)
  );

  nts_select #(
    .KEEP_COUNT (KEEP_COUNT),
    .ID_BITS    (ID_BITS),
    .DIST_W     (DIST_W)
  ) u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (dist_ctrl),
    .ready_o (sel_ready),
    .id_i    (dist_id),
    .dist_i  (dist_val),
    .res_o   (res_o)
  );

endmodule

>>> test/testbench.sv
// Testbench for nearest_three_selector: random and directed candidate lists, checked
// result by result against a behavioral model of the three-nearest selection.
// Depends on nts_pkg and the nts_cand_if, nts_res_if and nts_cfg_if interfaces.
`timescale 1ns / 1ps

module testbench;
  import nts_pkg::*;

  localparam int unsigned NUM_SLOTS    = KEEP_COUNT_DEF;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned SETTLE_TICKS = 6;
  localparam int unsigned MAX_REPORTS  = 30;
  // index 3 is not a register; writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = CFG_IDX_BITS'(3);

  typedef logic signed [COORD_BITS_DEF-1:0] coord_t;
  typedef logic [33:0] dist_t;

  typedef struct {
    logic [ID_BITS_DEF-1:0] id;
    coord_t                 x;
    coord_t                 y;
    coord_t                 z;
    logic                   last;
  } cand_t;

  typedef struct {
    logic [OUT_ID_BITS-1:0] slot_id [SLOT_OUTS];
    logic [COUNT_BITS-1:0]  count;
  } near_set_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  nts_cand_if cand_ch ();
  nts_res_if  res_ch ();
  nts_cfg_if  cfg_ch ();

  nearest_three_selector u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cand_i (cand_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // model state
  coord_t                 center_x, center_y, center_z;
  logic [ID_BITS_DEF-1:0] held_id   [NUM_SLOTS];
  dist_t                  held_dist [NUM_SLOTS];
  int unsigned            fill;
  int unsigned            far_slot;
  dist_t                  far_dist;
  near_set_t              nearest_q [$];

  int unsigned errors, n_cand, n_results, n_lists, n_centers, idle_cycles;
  bit          gap_on, stall_on;
  near_set_t   want;

  initial begin
    center_x = '0;
    center_y = '0;
    center_z = '0;
    fill     = 0;
    far_slot = 0;
    far_dist = '0;
    foreach (held_id[i]) begin
      held_id[i]   = '0;
      held_dist[i] = '0;
    end
  end

  function automatic dist_t sq_dist(input cand_t c);
    longint dx, dy, dz;
    dx = longint'(c.x) - longint'(center_x);
    dy = longint'(c.y) - longint'(center_y);
    dz = longint'(c.z) - longint'(center_z);
    return dist_t'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Fill phase tracks the farthest with >= (later slot wins); once full, a strictly
  // closer point replaces the farthest and the slots are rescanned (highest slot wins).
  function automatic void track_nearest(input cand_t c);
    dist_t     d;
    near_set_t r;
    d = sq_dist(c);
    if (fill < NUM_SLOTS) begin
      held_id[fill]   = c.id;
      held_dist[fill] = d;
      if (d >= far_dist) begin
        far_dist = d;
        far_slot = fill;
      end
      fill++;
    end else if (d < far_dist) begin
      held_id[far_slot]   = c.id;
      held_dist[far_slot] = d;
      far_dist = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (held_dist[i] >= far_dist) begin
          far_dist = held_dist[i];
          far_slot = i;
        end
      end
    end
    if (c.last) begin
      for (int i = 0; i < SLOT_OUTS; i++) begin
        r.slot_id[i] = (i < fill) ? held_id[i] : '0;
      end
      r.count = COUNT_BITS'(fill);
      nearest_q.push_back(r);
      fill     = 0;
      far_slot = 0;
      far_dist = '0;
      foreach (held_id[i]) begin
        held_id[i]   = '0;
        held_dist[i] = '0;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    if (errors < MAX_REPORTS) begin
      $display("mismatch at %0t, result %0d: %s got %0h, expected %0h",
               $realtime, n_results, what, got, exp_val);
    end
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (nearest_q.size() == 0) begin
        report_mismatch("result with nothing pending, slot0_id", res_ch.slot0_id, 0);
      end else begin
        want = nearest_q.pop_front();
        if (res_ch.slot0_id !== want.slot_id[0])
          report_mismatch("slot0_id", res_ch.slot0_id, want.slot_id[0]);
        if (res_ch.slot1_id !== want.slot_id[1])
          report_mismatch("slot1_id", res_ch.slot1_id, want.slot_id[1]);
        if (res_ch.slot2_id !== want.slot_id[2])
          report_mismatch("slot2_id", res_ch.slot2_id, want.slot_id[2]);
        if (res_ch.held_count !== want.count)
          report_mismatch("held_count", res_ch.held_count, want.count);
      end
      n_results++;
    end
  end

  // result-side backpressure
  initial begin : res_ready_drive
    int stall;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = stall_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((cand_ch.valid && cand_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // valid stays high between back-to-back transfers; it drops only ahead of a gap and at a phase end
  task automatic send_cand(input cand_t c);
    int gap;
    gap = gap_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      cand_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cand_ch.valid   <= 1'b1;
    cand_ch.cand_id <= c.id;
    cand_ch.cand_x  <= c.x;
    cand_ch.cand_y  <= c.y;
    cand_ch.cand_z  <= c.z;
    cand_ch.is_last <= c.last;
    do @(posedge clk_i); while (!cand_ch.ready);
    n_cand++;
    if (c.last) n_lists++;
    track_nearest(c);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_REF_X: center_x = coord_t'(val);
      REG_REF_Y: center_y = coord_t'(val);
      REG_REF_Z: center_z = coord_t'(val);
      default: ;
    endcase
  endtask

  task automatic set_center(input coord_t x, input coord_t y, input coord_t z,
                            input bit poke_unused);
    write_reg(REG_REF_X, x);
    write_reg(REG_REF_Y, y);
    write_reg(REG_REF_Z, z);
    if (poke_unused) write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom_range(1, 65535)));
    cfg_ch.valid <= 1'b0;
    n_centers++;
  endtask

  // block goes idle: all results in, then the pipeline settles
  task automatic end_phase();
    cand_ch.valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  function automatic cand_t cand_item(input int unsigned id, input int x, input int y,
                                      input int z, input bit last);
    cand_t c;
    c.id   = ID_BITS_DEF'(id);
    c.x    = coord_t'(x);
    c.y    = coord_t'(y);
    c.z    = coord_t'(z);
    c.last = last;
    return c;
  endfunction

  function automatic coord_t pick_coord(input coord_t around, input int unsigned mode);
    case (mode)
      0:       return around + coord_t'($urandom_range(0, 8)) - coord_t'(4);
      1:       return coord_t'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 2))
          0:       return coord_t'(-32768);
          1:       return coord_t'(32767);
          default: return coord_t'(0);
        endcase
      end
    endcase
  endfunction

  // mostly points clustered near the center so that ties and replacements happen
  function automatic cand_t random_cand(input bit last);
    cand_t       c;
    int unsigned mode;
    int unsigned r;
    r = $urandom_range(0, 9);
    mode = (r < 6) ? 0 : (r < 9) ? 1 : 2;
    c.id   = ($urandom_range(0, 15) == 0) ? '0 : ID_BITS_DEF'($urandom_range(0, 65535));
    c.x    = pick_coord(center_x, mode);
    c.y    = pick_coord(center_y, mode);
    c.z    = pick_coord(center_z, mode);
    c.last = last;
    return c;
  endfunction

  task automatic test_reset_center();
    // reference point still at its reset value
    gap_on   = 1'b0;
    stall_on = 1'b0;
    send_cand(cand_item(16'h0001, 0, 0, 0, 1'b1));       // two empty slots
    send_cand(cand_item(16'h0002, 1, 0, 0, 1'b0));       // tie while filling
    send_cand(cand_item(16'h0003, 0, 1, 0, 1'b1));
    gap_on   = 1'b1;
    stall_on = 1'b1;
    send_cand(cand_item(16'h0010, 3, 0, 0, 1'b0));
    send_cand(cand_item(16'h0011, 0, 0, 3, 1'b0));
    send_cand(cand_item(16'h0012, 1, 1, 1, 1'b0));
    send_cand(cand_item(16'h0013, 0, 3, 0, 1'b0));       // equal to farthest, kept out
    send_cand(cand_item(16'h0014, 2, 0, 0, 1'b0));       // replaces farthest
    send_cand(cand_item(16'h0015, 0, -2, 0, 1'b0));      // leaves a tie on rescan
    send_cand(cand_item(16'h0016, 0, 0, -1, 1'b1));      // hits the higher tied slot
    end_phase();
  endtask

  task automatic test_extreme_center();
    gap_on   = 1'b1;
    stall_on = 1'b1;
    set_center(coord_t'(-32768), coord_t'(-32768), coord_t'(-32768), 1'b1);
    send_cand(cand_item(16'hFFFF, 32767, 32767, 32767, 1'b0));   // largest distance
    send_cand(cand_item(16'h0000, -32768, -32768, -32768, 1'b0));
    send_cand(cand_item(16'h8000, 32767, -32768, 32767, 1'b0));
    send_cand(cand_item(16'h7FFF, -32768, 32767, -32768, 1'b1));
    end_phase();
    set_center(coord_t'(32767), coord_t'(32767), coord_t'(32767), 1'b0);
    send_cand(cand_item(16'h5555, -32768, -32768, -32768, 1'b0));
    send_cand(cand_item(16'hAAAA, -32768, -32768, -32768, 1'b0));
    send_cand(cand_item(16'h00FF, -32768, 0, 32767, 1'b0));
    send_cand(cand_item(16'hFF00, 32767, 32767, 32767, 1'b1));
    end_phase();
  endtask

  task automatic test_random_lists();
    int unsigned sent;
    int unsigned len;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_center(coord_t'(32767), coord_t'(32767), coord_t'(32767), 1'b0);
        1: set_center(coord_t'(-32768), coord_t'(-32768), coord_t'(-32768), 1'b1);
        2: set_center(coord_t'(-32768), coord_t'(32767), coord_t'(0), 1'b0);
        default: set_center(coord_t'($urandom_range(0, 65535)),
                            coord_t'($urandom_range(0, 65535)),
                            coord_t'($urandom_range(0, 65535)),
                            1'($urandom_range(0, 1)));
      endcase
      sent = 0;
      while (sent < 125) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
        gap_on   = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < len; i++) begin
          send_cand(random_cand(i == len - 1));
        end
        sent += len;
      end
      end_phase();
    end
  endtask

  initial begin
    errors      = 0;
    n_cand      = 0;
    n_results   = 0;
    n_lists     = 0;
    n_centers   = 0;
    gap_on      = 1'b0;
    stall_on    = 1'b0;
    rst_ni          <= 1'b0;
    cand_ch.valid   <= 1'b0;
    cand_ch.cand_id <= '0;
    cand_ch.cand_x  <= '0;
    cand_ch.cand_y  <= '0;
    cand_ch.cand_z  <= '0;
    cand_ch.is_last <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_center();
    test_extreme_center();
    test_random_lists();

    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (nearest_q.size() != 0) report_mismatch("results never delivered", 0,
                                               nearest_q.size());
    $display("covered %0d candidates in %0d lists over %0d reference points",
             n_cand, n_lists, n_centers);
    $display("checked %0d results, %0d mismatches", n_results, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
